/* hw/rtl/friction_velocity_update_assert.svh */
// Assertion macros for the friction velocity update block
`ifndef FRICTION_VELOCITY_UPDATE_ASSERT_SVH
`define FRICTION_VELOCITY_UPDATE_ASSERT_SVH
`ifndef ASSERT_OFF
// Clocked on clk, quiet while rst_n is low
`define FVU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked on clk, checked during reset too
`define FVU_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FVU_ASSERT(lbl, prop, msg)
`define FVU_ASSERT_RST(lbl, prop, msg)
`endif
`endif

/* hw/rtl/fvu_pkg.sv */
// Types, constants and helpers shared by the friction velocity update block
package fvu_pkg;

  localparam int FRAC_BITS = 16;
  localparam int TS_W      = 17;
  localparam int GRAV_W    = 24;
  localparam int CFG_W     = 24;

  localparam logic CFG_TIME_STEP = 1'b0;
  localparam logic CFG_GRAVITY   = 1'b1;

  localparam logic [TS_W-1:0]   TS_RESET   = 17'd655;
  localparam logic [GRAV_W-1:0] GRAV_RESET = 24'd642908;

  // dry friction force and its change over one step
  localparam int GM_W  = GRAV_W + 32 - FRAC_BITS;
  localparam int GM_LO = GM_W / 2;
  localparam int GM_HI = GM_W - GM_LO;
  localparam int FP_W  = GM_W + TS_W;
  localparam int FPS_W = (FP_W > 64) ? 64 : FP_W;
  localparam int FDT_W = FPS_W - FRAC_BITS;

  // viscous term
  localparam int Q_W   = 64 - FRAC_BITS;
  localparam int Q_LO  = Q_W / 2;
  localparam int Q_HI  = Q_W - Q_LO;
  localparam int VIS_W = 41;
  localparam logic [63:0] VISC_CAP = 64'd1 << 40;

  // stage map
  localparam int SQ_STAGES  = 16;
  localparam int DIV_STAGES = 8;
  localparam int SQ_BASE    = 4;
  localparam int SCALE_STG  = SQ_BASE + SQ_STAGES;
  localparam int DIV_BASE   = SCALE_STG + 1;
  localparam int FIN_STG    = DIV_BASE + DIV_STAGES;
  localparam int NSTG       = FIN_STG + 1;

  typedef struct packed {
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] spin;
    logic [31:0]        dry_coeff;
    logic [31:0]        visc_coeff;
    logic [31:0]        visc_spin_coeff;
  } in_t;

  typedef struct packed {
    logic signed [31:0] new_vel_x;
    logic signed [31:0] new_vel_y;
    logic signed [31:0] new_spin;
    logic               linear_stopped;
    logic               spin_stopped;
  } out_t;

  typedef struct packed {
    logic [31:0]       ax;
    logic [31:0]       ay;
    logic [31:0]       asp;
    logic              neg_x;
    logic              neg_y;
    logic              neg_s;
    logic [FDT_W-1:0]  fdt;
    logic [VIS_W-1:0]  vis_x;
    logic [VIS_W-1:0]  vis_y;
    logic [VIS_W-1:0]  vis_s;
  } mid_t;

  typedef struct packed {
    mid_t        mid;
    logic [31:0] mag;
    logic        lin_stop;
    logic        spin_stop;
  } dside_t;

  function automatic logic [63:0] sat64(input logic [127:0] x);
    return (|x[127:64]) ? {64{1'b1}} : x[63:0];
  endfunction

endpackage

/* hw/rtl/friction_velocity_update.sv */
// Top level of the friction velocity update pipeline
//
// Usage: one body enters per item on the in_ channel (velocity, spin and its
// friction coefficients); one item leaves on the out_ channel with the
// velocities after one Euler step and the two clamp flags.
// Both channels: an item moves at a rising edge with valid high, stall low.
// Throughput: one item per cycle while out_stall is low; an accepted item
// passes through all 30 register stages in order before it shows on
// out_valid, and the stages all advance together when nothing stalls.
// The long parts are the square root of vx^2+vy^2 (16 stages, two bits per
// stage) and the two divisions of the dry change by that magnitude
// (8 stages, four quotient bits per stage).
// Stalls: each stage holds its item only when the stage after it is full and
// not moving, so bubbles close up; in_stall rises only once the first stage
// holds an item that cannot advance. A stalled result holds on out_data.
// Reset (rst_n low at a clock edge) empties the pipeline and loads
// time_step = 655 and gravity = 642908. Write cfg_ registers only while idle.
module friction_velocity_update (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  fvu_pkg::in_t               in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output fvu_pkg::out_t              out_data,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [fvu_pkg::CFG_W-1:0]  cfg_wdata
);

  localparam int NSTG = fvu_pkg::NSTG;

  // configuration registers
  logic [fvu_pkg::TS_W-1:0]   ts_r;
  logic [fvu_pkg::GRAV_W-1:0] grav_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ts_r   <= fvu_pkg::TS_RESET;
      grav_r <= fvu_pkg::GRAV_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        fvu_pkg::CFG_TIME_STEP: ts_r   <= cfg_wdata[fvu_pkg::TS_W-1:0];
        fvu_pkg::CFG_GRAVITY:   grav_r <= cfg_wdata[fvu_pkg::GRAV_W-1:0];
        default: ;
      endcase
    end
  end

  // valid bits and per-stage advance
  logic [NSTG-1:0] vld_r, vld_nxt, en;

  assign en[NSTG-1] = ~vld_r[NSTG-1] | ~out_stall;
  for (genvar k = 0; k < NSTG - 1; k++) begin : g_en
    assign en[k] = ~vld_r[k] | en[k+1];
  end

  // shift in the new item wherever a stage advances, hold otherwise
  assign vld_nxt = (en & {vld_r[NSTG-2:0], in_valid}) | (~en & vld_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_stall  = ~en[0];
  assign out_valid = vld_r[NSTG-1];

  // front: magnitudes, squares, dry step, viscous terms
  logic [63:0]   sq_n [0:fvu_pkg::SQ_STAGES];
  logic [63:0]   sq_r [0:fvu_pkg::SQ_STAGES];
  fvu_pkg::mid_t sq_m [0:fvu_pkg::SQ_STAGES];

  fvu_front u_front (
    .clk     (clk),
    .en      (en[3:0]),
    .in_data (in_data),
    .ts      (ts_r),
    .grav    (grav_r),
    .sum_out (sq_n[0]),
    .mid_out (sq_m[0])
  );

  assign sq_r[0] = '0;

  // square root of vx^2 + vy^2
  for (genvar i = 0; i < fvu_pkg::SQ_STAGES; i++) begin : g_sqrt
    fvu_sqrt_stage u_sqrt (
      .clk       (clk),
      .en        (en[fvu_pkg::SQ_BASE + i]),
      .first_bit (6'(62 - 4 * i)),
      .n_in      (sq_n[i]),
      .r_in      (sq_r[i]),
      .mid_in    (sq_m[i]),
      .n_out     (sq_n[i+1]),
      .r_out     (sq_r[i+1]),
      .mid_out   (sq_m[i+1])
    );
  end

  // clamp decisions and dry products
  logic [31:0]     dv_remx [0:fvu_pkg::DIV_STAGES];
  logic [31:0]     dv_wx   [0:fvu_pkg::DIV_STAGES];
  logic [31:0]     dv_remy [0:fvu_pkg::DIV_STAGES];
  logic [31:0]     dv_wy   [0:fvu_pkg::DIV_STAGES];
  fvu_pkg::dside_t dv_ds   [0:fvu_pkg::DIV_STAGES];

  fvu_scale u_scale (
    .clk      (clk),
    .en       (en[fvu_pkg::SCALE_STG]),
    .r_in     (sq_r[fvu_pkg::SQ_STAGES]),
    .mid_in   (sq_m[fvu_pkg::SQ_STAGES]),
    .remx_out (dv_remx[0]),
    .wx_out   (dv_wx[0]),
    .remy_out (dv_remy[0]),
    .wy_out   (dv_wy[0]),
    .ds_out   (dv_ds[0])
  );

  // divide the dry products by the magnitude
  for (genvar i = 0; i < fvu_pkg::DIV_STAGES; i++) begin : g_div
    fvu_div_stage u_div (
      .clk      (clk),
      .en       (en[fvu_pkg::DIV_BASE + i]),
      .remx_in  (dv_remx[i]),
      .wx_in    (dv_wx[i]),
      .remy_in  (dv_remy[i]),
      .wy_in    (dv_wy[i]),
      .ds_in    (dv_ds[i]),
      .remx_out (dv_remx[i+1]),
      .wx_out   (dv_wx[i+1]),
      .remy_out (dv_remy[i+1]),
      .wy_out   (dv_wy[i+1]),
      .ds_out   (dv_ds[i+1])
    );
  end

  // final reductions and output register
  fvu_finish u_finish (
    .clk      (clk),
    .en       (en[fvu_pkg::FIN_STG]),
    .qx       (dv_wx[fvu_pkg::DIV_STAGES]),
    .qy       (dv_wy[fvu_pkg::DIV_STAGES]),
    .ds_in    (dv_ds[fvu_pkg::DIV_STAGES]),
    .out_data (out_data)
  );

  // terms for the clamp checks
  logic lin_clamp, lin_out_zero, spin_clamp, spin_out_zero;

  assign lin_clamp     = out_valid && out_data.linear_stopped;
  assign lin_out_zero  = (out_data.new_vel_x == '0) && (out_data.new_vel_y == '0);
  assign spin_clamp    = out_valid && out_data.spin_stopped;
  assign spin_out_zero = (out_data.new_spin == '0);

`include "friction_velocity_update_assert.svh"

  // input may only stall when the first stage holds an item
  `FVU_ASSERT(a_stall_needs_item, in_stall |-> vld_r[0], "input stalled with first stage empty")
  // reset empties every stage
  `FVU_ASSERT_RST(a_reset_empties, !rst_n |=> (vld_r == '0), "pipeline not empty after reset")
  // a linear clamp yields zero linear velocity
  `FVU_ASSERT(a_lin_zero, lin_clamp |-> lin_out_zero, "linear clamp with nonzero velocity")
  // a spin clamp yields zero spin
  `FVU_ASSERT(a_spin_zero, spin_clamp |-> spin_out_zero, "spin clamp with nonzero spin")

endmodule

/* hw/rtl/fvu_front.sv */
// Front stages: magnitudes, squares, dry friction step and viscous terms
module fvu_front (
  input  logic                            clk,
  input  logic [3:0]                      en,
  input  fvu_pkg::in_t                    in_data,
  input  logic [fvu_pkg::TS_W-1:0]        ts,
  input  logic [fvu_pkg::GRAV_W-1:0]      grav,
  output logic [63:0]                     sum_out,
  output fvu_pkg::mid_t                   mid_out
);

  localparam int F  = fvu_pkg::FRAC_BITS;
  localparam int TW = fvu_pkg::TS_W;
  localparam int GW = fvu_pkg::GM_W;
  localparam int GL = fvu_pkg::GM_LO;
  localparam int GH = fvu_pkg::GM_HI;
  localparam int QW = fvu_pkg::Q_W;
  localparam int QL = fvu_pkg::Q_LO;
  localparam int QH = fvu_pkg::Q_HI;
  localparam int GPW = fvu_pkg::GRAV_W + 32;

  function automatic logic [31:0] abs32(input logic signed [31:0] v);
    return v[31] ? 32'(-v) : 32'(v);
  endfunction

  function automatic logic [fvu_pkg::VIS_W-1:0] vis_of(input logic [QH+TW-1:0] h,
                                                       input logic [QL+TW-1:0] l);
    logic [127:0] s;
    logic [63:0]  v;
    s = (128'(h) << QL) + 128'(l);
    v = fvu_pkg::sat64(s) >> F;
    return (v > fvu_pkg::VISC_CAP) ? fvu_pkg::VIS_W'(fvu_pkg::VISC_CAP)
                                   : v[fvu_pkg::VIS_W-1:0];
  endfunction

  // stage 0
  fvu_pkg::mid_t    mid0_r;
  logic [GW-1:0]    gm0_r;
  logic [31:0]      cv0_r, cs0_r;
  // stage 1
  fvu_pkg::mid_t    mid1_r;
  logic [63:0]      sqx1_r, sqy1_r, pvx1_r, pvy1_r, pvs1_r;
  logic [GH+TW-1:0] fh1_r;
  logic [GL+TW-1:0] fl1_r;
  // stage 2
  fvu_pkg::mid_t    mid2_r;
  logic [63:0]      sum2_r;
  logic [QH+TW-1:0] qxh2_r, qyh2_r, qsh2_r;
  logic [QL+TW-1:0] qxl2_r, qyl2_r, qsl2_r;
  // stage 3
  fvu_pkg::mid_t    mid3_r;
  logic [63:0]      sum3_r;

  fvu_pkg::mid_t    mid0_nxt, mid2_nxt, mid3_nxt;
  logic [QW-1:0]    qx, qy, qs;
  logic [127:0]     fp;

  always_comb begin
    mid0_nxt       = '0;
    mid0_nxt.ax    = abs32(in_data.vel_x);
    mid0_nxt.ay    = abs32(in_data.vel_y);
    mid0_nxt.asp   = abs32(in_data.spin);
    mid0_nxt.neg_x = in_data.vel_x[31];
    mid0_nxt.neg_y = in_data.vel_y[31];
    mid0_nxt.neg_s = in_data.spin[31];
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      mid0_r <= mid0_nxt;
      gm0_r  <= GW'((GPW'(grav) * GPW'(in_data.dry_coeff)) >> F);
      cv0_r  <= in_data.visc_coeff;
      cs0_r  <= in_data.visc_spin_coeff;
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      mid1_r <= mid0_r;
      sqx1_r <= 64'(mid0_r.ax) * 64'(mid0_r.ax);
      sqy1_r <= 64'(mid0_r.ay) * 64'(mid0_r.ay);
      fh1_r  <= (GH+TW)'(gm0_r[GW-1:GL]) * (GH+TW)'(ts);
      fl1_r  <= (GL+TW)'(gm0_r[GL-1:0]) * (GL+TW)'(ts);
      pvx1_r <= 64'(mid0_r.ax) * 64'(cv0_r);
      pvy1_r <= 64'(mid0_r.ay) * 64'(cv0_r);
      pvs1_r <= 64'(mid0_r.asp) * 64'(cs0_r);
    end
  end

  always_comb begin
    qx = QW'(pvx1_r >> F);
    qy = QW'(pvy1_r >> F);
    qs = QW'(pvs1_r >> F);
    fp = (128'(fh1_r) << GL) + 128'(fl1_r);
    mid2_nxt       = mid1_r;
    mid2_nxt.fdt   = fvu_pkg::FDT_W'(fvu_pkg::sat64(fp) >> F);
    mid3_nxt       = mid2_r;
    mid3_nxt.vis_x = vis_of(qxh2_r, qxl2_r);
    mid3_nxt.vis_y = vis_of(qyh2_r, qyl2_r);
    mid3_nxt.vis_s = vis_of(qsh2_r, qsl2_r);
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      mid2_r     <= mid2_nxt;
      sum2_r     <= sqx1_r + sqy1_r;
      qxh2_r     <= (QH+TW)'(qx[QW-1:QL]) * (QH+TW)'(ts);
      qxl2_r     <= (QL+TW)'(qx[QL-1:0]) * (QL+TW)'(ts);
      qyh2_r     <= (QH+TW)'(qy[QW-1:QL]) * (QH+TW)'(ts);
      qyl2_r     <= (QL+TW)'(qy[QL-1:0]) * (QL+TW)'(ts);
      qsh2_r     <= (QH+TW)'(qs[QW-1:QL]) * (QH+TW)'(ts);
      qsl2_r     <= (QL+TW)'(qs[QL-1:0]) * (QL+TW)'(ts);
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      mid3_r <= mid3_nxt;
      sum3_r <= sum2_r;
    end
  end

  assign sum_out = sum3_r;
  assign mid_out = mid3_r;

endmodule

/* hw/rtl/fvu_sqrt_stage.sv */
// Two iterations of the bit-pair integer square root
module fvu_sqrt_stage (
  input  logic          clk,
  input  logic          en,
  input  logic [5:0]    first_bit,
  input  logic [63:0]   n_in,
  input  logic [63:0]   r_in,
  input  fvu_pkg::mid_t mid_in,
  output logic [63:0]   n_out,
  output logic [63:0]   r_out,
  output fvu_pkg::mid_t mid_out
);

  logic [63:0]   n_r, r_r;
  fvu_pkg::mid_t mid_r;
  logic [63:0]   b0, b1, t0, t1, n1, r1, n2, r2;

  always_comb begin
    b0 = 64'd1 << first_bit;
    b1 = b0 >> 2;
    t0 = r_in + b0;
    if (n_in >= t0) begin
      n1 = n_in - t0;
      r1 = (r_in >> 1) + b0;
    end else begin
      n1 = n_in;
      r1 = r_in >> 1;
    end
    t1 = r1 + b1;
    if (n1 >= t1) begin
      n2 = n1 - t1;
      r2 = (r1 >> 1) + b1;
    end else begin
      n2 = n1;
      r2 = r1 >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_r   <= n2;
      r_r   <= r2;
      mid_r <= mid_in;
    end
  end

  assign n_out   = n_r;
  assign r_out   = r_r;
  assign mid_out = mid_r;

endmodule

/* hw/rtl/fvu_scale.sv */
// Clamp decisions and the dry friction products to be divided by the magnitude
module fvu_scale (
  input  logic            clk,
  input  logic            en,
  input  logic [63:0]     r_in,
  input  fvu_pkg::mid_t   mid_in,
  output logic [31:0]     remx_out,
  output logic [31:0]     wx_out,
  output logic [31:0]     remy_out,
  output logic [31:0]     wy_out,
  output fvu_pkg::dside_t ds_out
);

  logic [31:0]     mag, fdt32;
  logic [63:0]     px, py;
  fvu_pkg::dside_t ds_r;
  logic [31:0]     remx_r, wx_r, remy_r, wy_r;

  always_comb begin
    mag   = r_in[31:0];
    fdt32 = 32'(mid_in.fdt);
    px    = 64'(fdt32) * 64'(mid_in.ax);
    py    = 64'(fdt32) * 64'(mid_in.ay);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ds_r.mid       <= mid_in;
      ds_r.mag       <= mag;
      ds_r.lin_stop  <= (mag != 32'd0) && (64'(mid_in.fdt) > 64'(mag));
      ds_r.spin_stop <= 64'(mid_in.fdt) > 64'(mid_in.asp);
      remx_r         <= px[63:32];
      wx_r           <= px[31:0];
      remy_r         <= py[63:32];
      wy_r           <= py[31:0];
    end
  end

  assign remx_out = remx_r;
  assign wx_out   = wx_r;
  assign remy_out = remy_r;
  assign wy_out   = wy_r;
  assign ds_out   = ds_r;

endmodule

/* hw/rtl/fvu_div_stage.sv */
// Four restoring division steps for the x and y lanes
module fvu_div_stage (
  input  logic            clk,
  input  logic            en,
  input  logic [31:0]     remx_in,
  input  logic [31:0]     wx_in,
  input  logic [31:0]     remy_in,
  input  logic [31:0]     wy_in,
  input  fvu_pkg::dside_t ds_in,
  output logic [31:0]     remx_out,
  output logic [31:0]     wx_out,
  output logic [31:0]     remy_out,
  output logic [31:0]     wy_out,
  output fvu_pkg::dside_t ds_out
);

  // dividend bits shift out of w at the top while quotient bits enter at the bottom
  function automatic logic [63:0] dstep4(input logic [31:0] rem, input logic [31:0] w,
                                         input logic [31:0] d);
    logic [32:0] t;
    logic [31:0] rm, wm;
    rm = rem;
    wm = w;
    for (int i = 0; i < 4; i++) begin
      t  = {rm, wm[31]};
      wm = {wm[30:0], 1'b0};
      if (t >= {1'b0, d}) begin
        rm    = 32'(t - {1'b0, d});
        wm[0] = 1'b1;
      end else begin
        rm = t[31:0];
      end
    end
    return {rm, wm};
  endfunction

  logic [63:0]     sx, sy;
  logic [31:0]     remx_r, wx_r, remy_r, wy_r;
  fvu_pkg::dside_t ds_r;

  always_comb begin
    sx = dstep4(remx_in, wx_in, ds_in.mag);
    sy = dstep4(remy_in, wy_in, ds_in.mag);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      remx_r <= sx[63:32];
      wx_r   <= sx[31:0];
      remy_r <= sy[63:32];
      wy_r   <= sy[31:0];
      ds_r   <= ds_in;
    end
  end

  assign remx_out = remx_r;
  assign wx_out   = wx_r;
  assign remy_out = remy_r;
  assign wy_out   = wy_r;
  assign ds_out   = ds_r;

endmodule

/* hw/rtl/fvu_finish.sv */
// Final stage: apply dry and viscous reductions, saturate, register the result
module fvu_finish (
  input  logic            clk,
  input  logic            en,
  input  logic [31:0]     qx,
  input  logic [31:0]     qy,
  input  fvu_pkg::dside_t ds_in,
  output fvu_pkg::out_t   out_data
);

  localparam logic signed [42:0] SMAX = 43'sd2147483647;
  localparam logic signed [42:0] SMIN = -43'sd2147483648;

  function automatic logic [31:0] fin(input logic [31:0] a, input logic neg,
                                      input logic [31:0] dry,
                                      input logic [fvu_pkg::VIS_W-1:0] vis);
    logic signed [42:0] m, r;
    m = $signed(43'(a)) - $signed(43'(dry)) - $signed(43'(vis));
    r = neg ? -m : m;
    if (r > SMAX) r = SMAX;
    if (r < SMIN) r = SMIN;
    return r[31:0];
  endfunction

  logic [31:0]   dx, dy;
  fvu_pkg::out_t out_r;

  always_comb begin
    dx = (qx > ds_in.mid.ax) ? ds_in.mid.ax : qx;
    dy = (qy > ds_in.mid.ay) ? ds_in.mid.ay : qy;
    if (ds_in.mag == 32'd0) begin
      dx = '0;
      dy = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r.new_vel_x <= ds_in.lin_stop ? '0 :
        fin(ds_in.mid.ax, ds_in.mid.neg_x, dx, ds_in.mid.vis_x);
      out_r.new_vel_y <= ds_in.lin_stop ? '0 :
        fin(ds_in.mid.ay, ds_in.mid.neg_y, dy, ds_in.mid.vis_y);
      out_r.new_spin  <= ds_in.spin_stop ? '0 :
        fin(ds_in.mid.asp, ds_in.mid.neg_s, 32'(ds_in.mid.fdt), ds_in.mid.vis_s);
      out_r.linear_stopped <= ds_in.lin_stop;
      out_r.spin_stopped   <= ds_in.spin_stop;
    end
  end

  assign out_data = out_r;

endmodule

/* tb/friction_velocity_update_tb.sv */
// Self-checking testbench for the friction velocity update pipeline
module friction_velocity_update_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY     = 30;
  localparam int WATCHDOG_MAX = 20000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  fvu_pkg::in_t  in_data;
  logic out_valid;
  logic out_stall;
  fvu_pkg::out_t out_data;
  logic cfg_we;
  logic cfg_index;
  logic [fvu_pkg::CFG_W-1:0] cfg_wdata;

  friction_velocity_update dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // Generate a 10 ns clock
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Shadow copy of the step and gravity registers
  logic [fvu_pkg::TS_W-1:0]   step_reg;
  logic [fvu_pkg::GRAV_W-1:0] grav_reg;

  fvu_pkg::in_t  pending_bodies[$];
  fvu_pkg::out_t expected_updates[$];

  int errors;
  int sent_count;
  int got_count;
  int lin_stop_count;
  int spin_stop_count;
  int send_idle_pct;
  int recv_stall_pct;
  bit hold_off;
  bit in_accepted;
  int watchdog;

  function automatic logic [63:0] mul_clip(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = a * b;
    return (|p[127:64]) ? 64'hFFFF_FFFF_FFFF_FFFF : p[63:0];
  endfunction

  function automatic logic [63:0] root_floor(input logic [63:0] n);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [63:0] drag_loss(input logic [63:0] mag, input logic [63:0] coeff);
    logic [63:0] d;
    d = mul_clip(mul_clip(mag, coeff) >> fvu_pkg::FRAC_BITS, 64'(step_reg))
        >> fvu_pkg::FRAC_BITS;
    return (d > fvu_pkg::VISC_CAP) ? fvu_pkg::VISC_CAP : d;
  endfunction

  // Reduce a magnitude toward zero by both losses, then clip to 32 bits
  function automatic logic signed [31:0] slow_down(input logic signed [63:0] v,
                                                   input logic [63:0] dry,
                                                   input logic [63:0] visc);
    logic [63:0] a;
    logic signed [63:0] m;
    logic signed [63:0] r;
    a = (v < 0) ? -v : v;
    m = $signed(a - dry) - $signed(visc);
    r = (v < 0) ? -m : m;
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    return r[31:0];
  endfunction

  function automatic fvu_pkg::out_t euler_step(input fvu_pkg::in_t b);
    fvu_pkg::out_t o;
    logic signed [63:0] vx, vy, sp;
    logic [63:0] ax, ay, asp, mag, force_mag, dv_dry, dx, dy;
    logic lin_stop, spin_stop;
    vx = b.vel_x;
    vy = b.vel_y;
    sp = b.spin;
    ax = (vx < 0) ? -vx : vx;
    ay = (vy < 0) ? -vy : vy;
    asp = (sp < 0) ? -sp : sp;
    force_mag = (64'(grav_reg) * 64'(b.dry_coeff)) >> fvu_pkg::FRAC_BITS;
    dv_dry = mul_clip(force_mag, 64'(step_reg)) >> fvu_pkg::FRAC_BITS;
    mag = root_floor(ax * ax + ay * ay);
    lin_stop = (mag != 0) && (dv_dry > mag);
    spin_stop = dv_dry > asp;
    if (lin_stop) begin
      o.new_vel_x = 0;
      o.new_vel_y = 0;
    end else begin
      dx = 0;
      dy = 0;
      if (mag != 0) begin
        dx = (dv_dry * ax) / mag;
        dy = (dv_dry * ay) / mag;
        if (dx > ax) dx = ax;
        if (dy > ay) dy = ay;
      end
      o.new_vel_x = slow_down(vx, dx, drag_loss(ax, 64'(b.visc_coeff)));
      o.new_vel_y = slow_down(vy, dy, drag_loss(ay, 64'(b.visc_coeff)));
    end
    o.new_spin = spin_stop ? 32'sd0 : slow_down(sp, dv_dry, drag_loss(asp, 64'(b.visc_spin_coeff)));
    o.linear_stopped = lin_stop;
    o.spin_stopped = spin_stop;
    return o;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h expected %h (result %0d)", what, got, want, got_count);
    errors++;
  endtask

  // Note whether the offered item was taken at the last rising edge
  always @(posedge clk) begin
    in_accepted <= in_valid && !in_stall;
  end

  // Drive one body per accepted handshake; hold payload while stalled
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_accepted) begin
      if (pending_bodies.size() > 0 && $urandom_range(99, 0) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_data <= pending_bodies.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Randomize receiver stall; a hold-off forces a long stall
  always @(negedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= hold_off || ($urandom_range(99, 0) < recv_stall_pct);
  end

  // Long hold-off counted in its own process so the pipeline fills and backs up
  initial begin
    hold_off = 1'b0;
    wait (sent_count > 1000);
    @(negedge clk);
    hold_off = 1'b1;
    repeat (150) @(posedge clk);
    hold_off = 1'b0;
  end

  // Predict on input accept; check on output accept
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        expected_updates.push_back(euler_step(in_data));
        sent_count++;
      end
      if (out_valid && !out_stall) begin
        got_count++;
        if (out_data.linear_stopped) lin_stop_count++;
        if (out_data.spin_stopped) spin_stop_count++;
        if (expected_updates.size() == 0) begin
          report_mismatch("unexpected item", 32'(out_data.new_spin), 0);
        end else begin
          fvu_pkg::out_t w;
          w = expected_updates.pop_front();
          if (out_data.new_vel_x !== w.new_vel_x)
            report_mismatch("new_vel_x", out_data.new_vel_x, w.new_vel_x);
          if (out_data.new_vel_y !== w.new_vel_y)
            report_mismatch("new_vel_y", out_data.new_vel_y, w.new_vel_y);
          if (out_data.new_spin !== w.new_spin)
            report_mismatch("new_spin", out_data.new_spin, w.new_spin);
          if (out_data.linear_stopped !== w.linear_stopped)
            report_mismatch("linear_stopped", 32'(out_data.linear_stopped),
                            32'(w.linear_stopped));
          if (out_data.spin_stopped !== w.spin_stopped)
            report_mismatch("spin_stopped", 32'(out_data.spin_stopped),
                            32'(w.spin_stopped));
        end
      end
    end
  end

  // Count cycles with no handshake; bail out when stuck
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      watchdog <= 0;
    end else if (watchdog >= WATCHDOG_MAX) begin
      $display("watchdog expired: %0d results outstanding", expected_updates.size());
      $display("FAIL friction_velocity_update");
      $finish;
    end else begin
      watchdog <= watchdog + 1;
    end
  end

  function automatic logic [31:0] rand_edgy32();
    case ($urandom_range(5, 0))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'(signed'($urandom_range(2000000, 0)) - 1000000);
      3: return 32'(signed'($urandom_range(200000000, 0)) - 100000000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] rand_coeff();
    case ($urandom_range(4, 0))
      0: return 32'(0);
      1: return $urandom_range(65536, 0);
      2: return $urandom_range(1048576, 0);
      3: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_body(input logic [31:0] vx, input logic [31:0] vy,
                            input logic [31:0] sp, input logic [31:0] mu,
                            input logic [31:0] cv, input logic [31:0] cs);
    fvu_pkg::in_t b;
    b.vel_x = vx;
    b.vel_y = vy;
    b.spin = sp;
    b.dry_coeff = mu;
    b.visc_coeff = cv;
    b.visc_spin_coeff = cs;
    pending_bodies.push_back(b);
  endtask

  // Drain everything, then let the pipeline go quiet before a register write
  task automatic drain_pipeline();
    wait (pending_bodies.size() == 0 && !in_valid && expected_updates.size() == 0);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [fvu_pkg::CFG_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx == fvu_pkg::CFG_TIME_STEP) step_reg = val[fvu_pkg::TS_W-1:0];
    else grav_reg = val[fvu_pkg::GRAV_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_phase(input int n, input int idle, input int stall);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    repeat (n) begin
      queue_body(rand_edgy32(), rand_edgy32(), rand_edgy32(), rand_coeff(),
                 rand_coeff(), rand_coeff());
    end
    drain_pipeline();
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_index = fvu_pkg::CFG_TIME_STEP;
    cfg_wdata = '0;
    step_reg = fvu_pkg::TS_RESET;
    grav_reg = fvu_pkg::GRAV_RESET;
    errors = 0;
    sent_count = 0;
    got_count = 0;
    lin_stop_count = 0;
    spin_stop_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: extremes, zero velocity, zero spin, clamps and no-clamp cases
    queue_body(0, 0, 0, 0, 0, 0);
    queue_body(0, 0, 0, 32'h0001_0000, 0, 0);
    queue_body(0, 0, 32'h0000_0100, 32'h0100_0000, 0, 0);
    queue_body(32'h0000_0100, 32'h0000_0100, 32'h8000_0000, 32'h0100_0000, 0, 0);
    queue_body(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
               32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_body(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 32'hFFFF_FFFF,
               32'hFFFF_FFFF);
    queue_body(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_8000,
               32'h0001_0000, 32'h0001_0000);
    queue_body(32'h0010_0000, 32'hFFF0_0000, 32'h0020_0000, 32'h0000_4000,
               32'h0000_8000, 32'h0002_0000);
    queue_body(32'hFFFF_FFFF, 0, 1, 32'h0000_0001, 0, 0);
    queue_body(0, 32'h0005_0000, 32'hFFFB_0000, 32'h0001_0000, 32'h0100_0000,
               32'h0100_0000);
    queue_body(32'h0000_6000, 32'h0000_8000, 32'h0000_A000, 32'h0000_1000, 0, 0);
    drain_pipeline();

    // Zero time step: no change, no flag
    write_reg(fvu_pkg::CFG_TIME_STEP, 0);
    queue_body(32'h0000_1000, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
               32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_body(0, 0, 0, 32'hFFFF_FFFF, 0, 0);
    random_phase(60, 0, 0);

    // Largest step and gravity
    write_reg(fvu_pkg::CFG_TIME_STEP, 24'hFFFFFF);
    write_reg(fvu_pkg::CFG_GRAVITY, 24'hFFFFFF);
    queue_body(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF,
               32'hFFFF_FFFF, 32'hFFFF_FFFF);
    random_phase(200, 0, 0);

    write_reg(fvu_pkg::CFG_TIME_STEP, 24'h10000);
    write_reg(fvu_pkg::CFG_GRAVITY, 0);
    random_phase(150, 69, 0);

    write_reg(fvu_pkg::CFG_TIME_STEP, 24'h01000);
    write_reg(fvu_pkg::CFG_GRAVITY, fvu_pkg::GRAV_RESET);
    random_phase(250, 0, 69);

    write_reg(fvu_pkg::CFG_TIME_STEP, fvu_pkg::CFG_W'(fvu_pkg::TS_RESET));
    write_reg(fvu_pkg::CFG_GRAVITY, 24'h123456);
    random_phase(220, 15, 15);

    // Back-pressure phase: the long hold-off lands here
    write_reg(fvu_pkg::CFG_TIME_STEP, 24'h1FFFF);
    write_reg(fvu_pkg::CFG_GRAVITY, 24'd1);
    random_phase(250, 0, 10);

    repeat (LATENCY + 10) @(posedge clk);
    $display("covered %0d bodies over 7 register settings and 5 idle/stall mixes",
             sent_count);
    $display("results %0d, linear clamps %0d, spin clamps %0d, errors %0d",
             got_count, lin_stop_count, spin_stop_count, errors);
    if (errors == 0 && expected_updates.size() == 0) begin
      $display("PASS friction_velocity_update");
    end else begin
      $display("FAIL friction_velocity_update");
    end
    $finish;
  end

endmodule
